// ===== rtl/pfa_pkg.sv =====
// Package: sizes, codes, types and the init classification of the page frame allocator.
package pfa_pkg;

    localparam int PAGE_SLOTS = 32768;
    localparam int COUNT_BITS = 16;
    localparam int FRAME_BITS = $clog2(PAGE_SLOTS);
    localparam int DEPTH_BITS = $clog2(PAGE_SLOTS + 1);
    localparam int CFG_BITS   = 16;
    localparam int REC_BITS   = COUNT_BITS + 1;

    typedef logic [FRAME_BITS-1:0] t_frame;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [DEPTH_BITS-1:0] t_depth;

    localparam t_count COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam t_depth DEPTH_FULL = DEPTH_BITS'(PAGE_SLOTS);

    // register indexes on the config port
    localparam logic [2:0] CFG_TOTAL_PAGES     = 3'd0;
    localparam logic [2:0] CFG_BASE_PAGES      = 3'd1;
    localparam logic [2:0] CFG_HOLE_FIRST_PAGE = 3'd2;
    localparam logic [2:0] CFG_HOLE_END_PAGE   = 3'd3;
    localparam logic [2:0] CFG_FREE_START_PAGE = 3'd4;

    typedef enum logic [2:0] {
        MODE_INIT  = 3'd0,
        MODE_ALLOC = 3'd1,
        MODE_FREE  = 3'd2,
        MODE_DEC   = 3'd3,
        MODE_INC   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_EMPTY   = 3'd1,
        STAT_REFUSED = 3'd2,
        STAT_RANGE   = 3'd3,
        STAT_LIMIT   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP
    } t_state;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_USED,
        KIND_FREE
    } t_kind;

    typedef struct packed {
        logic [15:0] total_pages;
        logic [7:0]  base_pages;
        logic [15:0] hole_first_page;
        logic [15:0] hole_end_page;
        logic [15:0] free_start_page;
        logic [15:0] frames;        // min(total_pages, PAGE_SLOTS)
    } t_cfg;

    // Boot-time role of frame f; the later rule in the list wins.
    function automatic t_kind init_kind(input t_frame f, input t_cfg cfg);
        logic [15:0] fx;
        t_kind       k;
        fx = 16'(f);
        k  = KIND_NONE;
        if (fx >= cfg.frames) begin
            k = KIND_NONE;
        end else if (fx >= cfg.free_start_page) begin
            k = KIND_FREE;
        end else if (fx >= cfg.hole_end_page) begin
            k = KIND_USED;
        end else if (fx >= cfg.hole_first_page) begin
            k = KIND_USED;
        end else if (fx >= 16'd1 && fx < 16'(cfg.base_pages)) begin
            k = KIND_FREE;
        end else if (fx == 16'd0) begin
            k = KIND_USED;
        end
        return k;
    endfunction

endpackage

// ===== rtl/pfa_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered data.
module pfa_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== rtl/pfa_cfg.sv =====
// Configuration register file and the derived usable frame count.
module pfa_cfg
    import pfa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    output t_cfg                o_cfg
);

    logic [15:0] r_total_pages;
    logic [7:0]  r_base_pages;
    logic [15:0] r_hole_first_page;
    logic [15:0] r_hole_end_page;
    logic [15:0] r_free_start_page;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_pages     <= 16'd32768;
            r_base_pages      <= 8'd160;
            r_hole_first_page <= 16'd160;
            r_hole_end_page   <= 16'd256;
            r_free_start_page <= 16'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TOTAL_PAGES:     r_total_pages     <= i_cfg_data[15:0];
                CFG_BASE_PAGES:      r_base_pages      <= i_cfg_data[7:0];
                CFG_HOLE_FIRST_PAGE: r_hole_first_page <= i_cfg_data[15:0];
                CFG_HOLE_END_PAGE:   r_hole_end_page   <= i_cfg_data[15:0];
                CFG_FREE_START_PAGE: r_free_start_page <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.total_pages     = r_total_pages;
        o_cfg.base_pages      = r_base_pages;
        o_cfg.hole_first_page = r_hole_first_page;
        o_cfg.hole_end_page   = r_hole_end_page;
        o_cfg.free_start_page = r_free_start_page;
        o_cfg.frames = (32'(r_total_pages) < PAGE_SLOTS) ? r_total_pages
                                                         : 16'(PAGE_SLOTS);
    end

endmodule

// ===== rtl/page_frame_allocator.sv =====
// Page frame allocator: reference counts and a LIFO free-frame stack in two RAMs.
//
// Input channel: i_in_valid / o_in_stall carry a word of {i_mode, i_frame_number}.
// Output channel: o_out_valid / i_out_stall carry one result word per input word.
// A word moves on a clock edge where valid is high and stall is low.
// For allocate, free, decrement and increment, the accept cycle reads the frame
// record RAM (or the top of the stack RAM), the next cycle modifies the record,
// writes it back, pushes if needed and loads the result register. The next word
// is taken only once the block is idle again, so one word's read-modify-write
// is written back before the RAM read for the next word.
// An init word sweeps all PAGE_SLOTS frame records, one per cycle, pushing free
// frames in ascending order; its result is registered when the sweep writes the
// last frame record. Init must come first.
// Reset clears the stack depth, the control state and the config registers to
// their defaults; RAM contents are left as they are. While the receiver stalls,
// the result register holds and a new word is taken only if that result leaves
// in the same cycle. Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) must go in
// only while the block is idle; the block itself does not enforce this.
module page_frame_allocator
    import pfa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_mode,
    input  t_frame              i_frame_number,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_frame              o_result_frame,
    output logic [15:0]         o_ref_count,
    output logic [2:0]          o_status,
    output logic                o_was_freed
);

    t_cfg cfg;

    pfa_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // frame record: {count, on_free_list}
    logic                rec_we;
    t_frame              rec_waddr;
    logic [REC_BITS-1:0] rec_wdata;
    logic [REC_BITS-1:0] rec_rdata;
    logic                stk_we;
    t_frame              stk_waddr;
    t_frame              stk_wdata;
    t_frame              stk_raddr;
    t_frame              stk_rdata;

    t_state  r_state, n_state;
    t_depth  r_depth, n_depth;
    t_frame  r_sweep, n_sweep;
    t_mode   r_mode, n_mode;
    t_frame  r_frame, n_frame;
    logic    r_inrange, n_inrange;
    logic    r_out_valid, n_out_valid;
    t_frame  r_res_frame, n_res_frame;
    t_count  r_res_count, n_res_count;
    t_status r_res_status, n_res_status;
    logic    r_res_freed, n_res_freed;

    logic    accept;
    t_count  cnt;
    logic    listed;
    logic    push_ok;
    t_count  cnt_dec;
    t_kind   kind;

    assign stk_raddr = FRAME_BITS'(r_depth - 1'b1);

    pfa_ram #(.DEPTH(PAGE_SLOTS), .WIDTH(REC_BITS)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (rec_waddr),
        .i_wdata (rec_wdata),
        .i_raddr (i_frame_number),
        .o_rdata (rec_rdata)
    );

    pfa_ram #(.DEPTH(PAGE_SLOTS), .WIDTH(FRAME_BITS)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign o_in_stall = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    assign cnt     = rec_rdata[REC_BITS-1:1];
    assign listed  = rec_rdata[0];
    assign push_ok = (r_depth < DEPTH_FULL);
    assign cnt_dec = cnt - 1'b1;
    assign kind    = init_kind(r_sweep, cfg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sweep      <= n_sweep;
        r_mode       <= n_mode;
        r_frame      <= n_frame;
        r_inrange    <= n_inrange;
        r_res_frame  <= n_res_frame;
        r_res_count  <= n_res_count;
        r_res_status <= n_res_status;
        r_res_freed  <= n_res_freed;
    end

    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_sweep      = r_sweep;
        n_mode       = r_mode;
        n_frame      = r_frame;
        n_inrange    = r_inrange;
        n_out_valid  = r_out_valid && i_out_stall;
        n_res_frame  = r_res_frame;
        n_res_count  = r_res_count;
        n_res_status = r_res_status;
        n_res_freed  = r_res_freed;
        rec_we       = 1'b0;
        rec_waddr    = r_frame;
        rec_wdata    = '0;
        stk_we       = 1'b0;
        stk_waddr    = r_depth[FRAME_BITS-1:0];
        stk_wdata    = r_frame;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_mode    = t_mode'(i_mode);
                    n_frame   = i_frame_number;
                    n_inrange = (16'(i_frame_number) < cfg.frames);
                    if (t_mode'(i_mode) == MODE_INIT) begin
                        n_depth = '0;
                        n_sweep = '0;
                        n_state = ST_SWEEP;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end

            ST_SWEEP: begin
                rec_we    = 1'b1;
                rec_waddr = r_sweep;
                stk_wdata = r_sweep;
                case (kind)
                    KIND_USED: rec_wdata = {COUNT_BITS'(1), 1'b0};
                    KIND_FREE: begin
                        rec_wdata = {COUNT_BITS'(0), push_ok};
                        if (push_ok) begin
                            stk_we  = 1'b1;
                            n_depth = r_depth + 1'b1;
                        end
                    end
                    default: rec_wdata = '0;
                endcase
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == {FRAME_BITS{1'b1}}) begin
                    n_out_valid  = 1'b1;
                    n_res_frame  = r_frame;
                    n_res_count  = '0;
                    n_res_status = STAT_OK;
                    n_res_freed  = 1'b0;
                    n_state      = ST_IDLE;
                end
            end

            ST_EXEC: begin
                n_state      = ST_IDLE;
                n_out_valid  = 1'b1;
                n_res_frame  = r_frame;
                n_res_count  = '0;
                n_res_status = STAT_OK;
                n_res_freed  = 1'b0;
                case (r_mode)
                    MODE_ALLOC: begin
                        if (r_depth == '0 || r_depth > DEPTH_FULL) begin
                            n_res_status = STAT_EMPTY;
                            n_res_frame  = '0;
                        end else begin
                            n_depth     = r_depth - 1'b1;
                            rec_we      = 1'b1;
                            rec_waddr   = stk_rdata;
                            rec_wdata   = '0;
                            n_res_frame = stk_rdata;
                        end
                    end
                    MODE_FREE: begin
                        if (!r_inrange) begin
                            n_res_status = STAT_RANGE;
                        end else begin
                            n_res_count = cnt;
                            if (cnt != '0 || listed) begin
                                n_res_status = STAT_REFUSED;
                            end else begin
                                rec_we      = 1'b1;
                                rec_wdata   = {cnt, push_ok};
                                n_res_freed = 1'b1;
                                if (push_ok) begin
                                    stk_we  = 1'b1;
                                    n_depth = r_depth + 1'b1;
                                end
                            end
                        end
                    end
                    MODE_DEC: begin
                        if (!r_inrange) begin
                            n_res_status = STAT_RANGE;
                        end else if (cnt == '0) begin
                            n_res_status = STAT_LIMIT;
                        end else begin
                            rec_we      = 1'b1;
                            rec_wdata   = {cnt_dec, listed};
                            n_res_count = cnt_dec;
                            if (cnt_dec == '0) begin
                                if (listed) begin
                                    n_res_status = STAT_REFUSED;
                                end else begin
                                    rec_wdata   = {cnt_dec, push_ok};
                                    n_res_freed = 1'b1;
                                    if (push_ok) begin
                                        stk_we  = 1'b1;
                                        n_depth = r_depth + 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    MODE_INC: begin
                        if (!r_inrange) begin
                            n_res_status = STAT_RANGE;
                        end else if (cnt == COUNT_MAX) begin
                            n_res_status = STAT_LIMIT;
                            n_res_count  = cnt;
                        end else begin
                            rec_we      = 1'b1;
                            rec_wdata   = {cnt + 1'b1, listed};
                            n_res_count = cnt + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_frame = r_res_frame;
    assign o_ref_count    = 16'(r_res_count);
    assign o_status       = r_res_status;
    assign o_was_freed    = r_res_freed;

    // stack never grows past its slots
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_FULL)
        else $error("free stack depth beyond capacity");

    // an operation item always completes into the result register
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> (o_out_valid && r_state == ST_IDLE))
        else $error("exec cycle did not produce a result");

    // result register is free whenever an operation finishes
    a_exec_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC || r_state == ST_SWEEP) |-> !(r_out_valid && i_out_stall))
        else $error("result register busy at completion");

    // a successful allocate pops exactly one entry
    a_alloc_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_mode == MODE_ALLOC && r_depth != '0)
        |=> (r_depth == $past(r_depth) - 1'b1))
        else $error("allocate did not pop the stack");

    // init starts from an empty stack
    a_init_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == MODE_INIT) |=> (r_depth == '0 && r_state == ST_SWEEP))
        else $error("init did not clear the stack");

endmodule

// ===== bench/tb.sv =====
// Testbench for page_frame_allocator: directed table and random phases.
`timescale 1ns / 1ps

module tb;
    import pfa_pkg::*;

    // result word as the block returns it
    typedef struct packed {
        t_frame      frame;
        t_count      count;
        t_status     status;
        logic        freed;
    } t_result;

    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  code;      // mode, or register index for a config row
        logic [15:0] value;     // frame number, or register data
        logic        typed;
        t_result     want;
    } t_row;

    typedef struct packed {
        logic [15:0] total;
        logic [7:0]  base;
        logic [15:0] hole_first;
        logic [15:0] hole_end;
        logic [15:0] first_free;
    } t_layout;

    localparam logic       ROW_WORD = 1'b0;
    localparam logic       ROW_CFG  = 1'b1;
    localparam logic       TYPED    = 1'b1;
    localparam logic       PREDICT  = 1'b0;
    localparam logic [2:0] MODE_RSVD_LO = 3'd5;
    localparam logic [2:0] MODE_RSVD_HI = 3'd7;
    localparam t_result    UNTYPED  = '{'0, '0, STAT_OK, 1'b0};
    localparam int         NUM_PHASES = 9;
    localparam int         NUM_FIXED  = 6;
    localparam int         PHASE_WORDS = 100;

    localparam t_row DIRECTED [31] = '{
        // reset layout: frames 1..159 and 1024..32767 free, top is 32767
        '{ROW_WORD, MODE_INIT,    16'h7fff, TYPED,   '{15'h7fff, 16'd0, STAT_OK, 1'b0}},
        '{ROW_WORD, MODE_ALLOC,   16'h0000, TYPED,   '{15'h7fff, 16'd0, STAT_OK, 1'b0}},
        '{ROW_WORD, MODE_ALLOC,   16'h1234, TYPED,   '{15'h7ffe, 16'd0, STAT_OK, 1'b0}},
        '{ROW_WORD, MODE_FREE,    16'h7fff, TYPED,   '{15'h7fff, 16'd0, STAT_OK, 1'b1}},
        '{ROW_WORD, MODE_FREE,    16'h7fff, TYPED,   '{15'h7fff, 16'd0, STAT_REFUSED, 1'b0}},
        '{ROW_WORD, MODE_FREE,    16'h0000, TYPED,   '{15'h0000, 16'd1, STAT_REFUSED, 1'b0}},
        '{ROW_WORD, MODE_INC,     16'h0000, TYPED,   '{15'h0000, 16'd2, STAT_OK, 1'b0}},
        '{ROW_WORD, MODE_DEC,     16'h0000, TYPED,   '{15'h0000, 16'd1, STAT_OK, 1'b0}},
        '{ROW_WORD, MODE_DEC,     16'h0000, TYPED,   '{15'h0000, 16'd0, STAT_OK, 1'b1}},
        '{ROW_WORD, MODE_DEC,     16'h0000, TYPED,   '{15'h0000, 16'd0, STAT_LIMIT, 1'b0}},
        '{ROW_WORD, MODE_ALLOC,   16'h0000, TYPED,   '{15'h0000, 16'd0, STAT_OK, 1'b0}},
        // listed frame with a count: reaching zero must not push it twice
        '{ROW_WORD, MODE_INC,     16'h0005, TYPED,   '{15'h0005, 16'd1, STAT_OK, 1'b0}},
        '{ROW_WORD, MODE_DEC,     16'h0005, TYPED,   '{15'h0005, 16'd0, STAT_REFUSED, 1'b0}},
        '{ROW_WORD, MODE_DEC,     16'd200,  PREDICT, UNTYPED},
        '{ROW_WORD, MODE_INC,     16'd1023, PREDICT, UNTYPED},
        '{ROW_WORD, MODE_RSVD_LO, 16'h7fff, TYPED,   '{15'h7fff, 16'd0, STAT_OK, 1'b0}},
        '{ROW_WORD, MODE_ALLOC,   16'h0000, PREDICT, UNTYPED},
        // single frame, every boundary at zero
        '{ROW_CFG,  CFG_TOTAL_PAGES,     16'd1, PREDICT, UNTYPED},
        '{ROW_CFG,  CFG_BASE_PAGES,      16'd0, PREDICT, UNTYPED},
        '{ROW_CFG,  CFG_HOLE_FIRST_PAGE, 16'd0, PREDICT, UNTYPED},
        '{ROW_CFG,  CFG_HOLE_END_PAGE,   16'd0, PREDICT, UNTYPED},
        '{ROW_CFG,  CFG_FREE_START_PAGE, 16'd0, PREDICT, UNTYPED},
        '{ROW_WORD, MODE_INIT,    16'h0000, TYPED,   '{15'h0000, 16'd0, STAT_OK, 1'b0}},
        '{ROW_WORD, MODE_FREE,    16'h0001, TYPED,   '{15'h0001, 16'd0, STAT_RANGE, 1'b0}},
        '{ROW_WORD, MODE_INC,     16'h7fff, TYPED,   '{15'h7fff, 16'd0, STAT_RANGE, 1'b0}},
        '{ROW_WORD, MODE_DEC,     16'h4000, TYPED,   '{15'h4000, 16'd0, STAT_RANGE, 1'b0}},
        '{ROW_WORD, MODE_ALLOC,   16'h0000, TYPED,   '{15'h0000, 16'd0, STAT_OK, 1'b0}},
        '{ROW_WORD, MODE_ALLOC,   16'h0000, TYPED,   '{15'h0000, 16'd0, STAT_EMPTY, 1'b0}},
        '{ROW_WORD, MODE_RSVD_HI, 16'h2aaa, TYPED,   '{15'h2aaa, 16'd0, STAT_OK, 1'b0}},
        '{ROW_WORD, MODE_FREE,    16'h0000, TYPED,   '{15'h0000, 16'd0, STAT_OK, 1'b1}},
        '{ROW_WORD, MODE_ALLOC,   16'h0000, TYPED,   '{15'h0000, 16'd0, STAT_OK, 1'b0}}
    };

    localparam t_layout FIXED_LAYOUTS [NUM_FIXED] = '{
        '{16'd32768, 8'd160, 16'd160,   16'd256,   16'd1024},
        '{16'd48,    8'd16,  16'd16,    16'd24,    16'd32},
        '{16'd20,    8'd160, 16'd5,     16'd8,     16'd10},
        '{16'd64,    8'd0,   16'd32768, 16'd32768, 16'd32768},
        '{16'd30,    8'd10,  16'd20,    16'd15,    16'd25},    // hole end below its start
        '{16'd32768, 8'd0,   16'd0,     16'd0,     16'd0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [2:0]          i_cfg_idx;
    logic [CFG_BITS-1:0] i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [2:0]          i_mode;
    t_frame              i_frame_number;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_frame              o_result_frame;
    logic [15:0]         o_ref_count;
    logic [2:0]          o_status;
    logic                o_was_freed;

    page_frame_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_frame_number (i_frame_number),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_frame (o_result_frame),
        .o_ref_count    (o_ref_count),
        .o_status       (o_status),
        .o_was_freed    (o_was_freed)
    );

    always #6 i_clk = ~i_clk;

    // shadow of the allocator
    t_count      frame_count  [PAGE_SLOTS];
    logic        frame_listed [PAGE_SLOTS];
    t_frame      free_frames  [PAGE_SLOTS];
    int unsigned free_depth;
    logic [15:0] cfg_total;
    logic [7:0]  cfg_base;
    logic [15:0] cfg_hole_first;
    logic [15:0] cfg_hole_end;
    logic [15:0] cfg_first_free;

    t_result     results_due [$];
    t_frame      held_frames [$];
    bit          quiet;
    int unsigned mismatches;
    int unsigned words_sent;
    int unsigned results_seen;
    int unsigned inits_sent;
    int unsigned status_seen [8];
    int          stall_left;

    function automatic int unsigned frames_live();
        return (cfg_total < PAGE_SLOTS) ? cfg_total : PAGE_SLOTS;
    endfunction

    function automatic void push_free(input t_frame f);
        if (free_depth < PAGE_SLOTS) begin
            free_frames[free_depth] = f;
            free_depth++;
            frame_listed[f] = 1'b1;
        end
    endfunction

    // Applies one word to the shadow state and returns the result it must produce.
    function automatic t_result next_frame_result(input logic [2:0] mode, input t_frame f);
        t_result r;
        t_count  c;
        logic    in_range;
        r = '{f, '0, STAT_OK, 1'b0};
        in_range = 32'(f) < frames_live();
        case (mode)
            MODE_INIT: begin
                for (int g = 0; g < PAGE_SLOTS; g++) begin
                    frame_count[g]  = '0;
                    frame_listed[g] = 1'b0;
                end
                free_depth = 0;
                // later rule wins: tested from the highest-priority rule down
                for (int g = 0; g < int'(frames_live()); g++) begin
                    if (g >= cfg_first_free) begin
                        push_free(t_frame'(g));
                    end else if (g >= cfg_hole_end || g >= cfg_hole_first) begin
                        frame_count[g] = t_count'(1);
                    end else if (g >= 1 && g < cfg_base) begin
                        push_free(t_frame'(g));
                    end else if (g == 0) begin
                        frame_count[g] = t_count'(1);
                    end
                end
            end
            MODE_ALLOC: begin
                if (free_depth == 0) begin
                    r.status = STAT_EMPTY;
                    r.frame  = '0;
                end else begin
                    free_depth--;
                    r.frame = free_frames[free_depth];
                    frame_count[r.frame]  = '0;
                    frame_listed[r.frame] = 1'b0;
                end
            end
            MODE_FREE, MODE_DEC, MODE_INC: begin
                if (!in_range) begin
                    r.status = STAT_RANGE;
                end else begin
                    c = frame_count[f];
                    r.count = c;
                    if (mode == MODE_FREE) begin
                        if (c != 0 || frame_listed[f]) begin
                            r.status = STAT_REFUSED;
                        end else begin
                            push_free(f);
                            r.freed = 1'b1;
                        end
                    end else if (mode == MODE_DEC) begin
                        if (c == 0) begin
                            r.status = STAT_LIMIT;
                        end else begin
                            c--;
                            frame_count[f] = c;
                            r.count = c;
                            if (c == 0) begin
                                if (frame_listed[f]) begin
                                    r.status = STAT_REFUSED;
                                end else begin
                                    push_free(f);
                                    r.freed = 1'b1;
                                end
                            end
                        end
                    end else begin
                        if (c == COUNT_MAX) begin
                            r.status = STAT_LIMIT;
                        end else begin
                            c++;
                            frame_count[f] = c;
                            r.count = c;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_frame pick_frame();
        int unsigned roll;
        int unsigned top;
        roll = $urandom_range(0, 99);
        top  = (frames_live() + 1 > 32767) ? 32767 : frames_live() + 1;
        if (roll < 25 && held_frames.size() != 0) begin
            return held_frames[$urandom_range(0, held_frames.size() - 1)];
        end
        if (roll < 85) begin
            return t_frame'($urandom_range(0, top));
        end
        return t_frame'($urandom());
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        mismatches++;
        $display("ERROR result %0d %s: got 0x%0h, want 0x%0h", results_seen, what, got, want);
    endtask

    task automatic send_word(input logic [2:0] mode, input t_frame f, input logic typed,
                             input t_result typed_want, output t_result predicted);
        int unsigned gap;
        int unsigned roll;
        gap = 0;
        if (!quiet) begin
            roll = $urandom_range(0, 99);
            if (roll >= 92) begin
                gap = $urandom_range(8, 40);
            end else if (roll >= 55) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_frame_number <= f;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = next_frame_result(mode, f);
        results_due.push_back(typed ? typed_want : predicted);
        words_sent++;
        if (mode == MODE_INIT) inits_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TOTAL_PAGES:     cfg_total      = value;
            CFG_BASE_PAGES:      cfg_base       = value[7:0];
            CFG_HOLE_FIRST_PAGE: cfg_hole_first = value;
            CFG_HOLE_END_PAGE:   cfg_hole_end   = value;
            CFG_FREE_START_PAGE: cfg_first_free = value;
            default: ;
        endcase
    endtask

    // receiver backpressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else if (!quiet && $urandom_range(0, 99) < 25) begin
            i_out_stall <= 1'b1;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) - 1
                                                     : $urandom_range(1, 3) - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            status_seen[o_status]++;
            if (results_due.size() == 0) begin
                flag_mismatch("arrived with nothing due", o_result_frame, 0);
            end else begin
                want = results_due.pop_front();
                if (o_result_frame !== want.frame)
                    flag_mismatch("result_frame", o_result_frame, want.frame);
                if (o_ref_count !== want.count)
                    flag_mismatch("ref_count", o_ref_count, want.count);
                if (o_status !== want.status)
                    flag_mismatch("status", o_status, want.status);
                if (o_was_freed !== want.freed)
                    flag_mismatch("was_freed", o_was_freed, want.freed);
            end
        end
    end

    initial begin : stimulus
        t_result     res;
        t_layout     lay;
        t_frame      f;
        logic [2:0]  m;
        int unsigned roll;
        int unsigned k;
        int unsigned phase_goal;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_TOTAL_PAGES;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_mode         = MODE_INIT;
        i_frame_number = '0;
        stall_left     = 0;
        quiet          = 1'b0;
        mismatches     = 0;
        words_sent     = 0;
        results_seen   = 0;
        inits_sent     = 0;
        free_depth     = 0;
        cfg_total      = 16'd32768;
        cfg_base       = 8'd160;
        cfg_hole_first = 16'd160;
        cfg_hole_end   = 16'd256;
        cfg_first_free = 16'd1024;
        foreach (status_seen[s]) status_seen[s] = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < $size(DIRECTED); i++) begin
            if (DIRECTED[i].is_cfg) begin
                drain_results();
                write_reg(DIRECTED[i].code, DIRECTED[i].value);
            end else begin
                send_word(DIRECTED[i].code, t_frame'(DIRECTED[i].value), DIRECTED[i].typed,
                          DIRECTED[i].want, res);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < NUM_FIXED) begin
                lay = FIXED_LAYOUTS[p];
            end else begin
                lay.total      = 16'($urandom_range(1, 64));
                lay.base       = 8'($urandom_range(0, 40));
                lay.hole_first = 16'($urandom_range(0, 64));
                lay.hole_end   = 16'($urandom_range(0, 64));
                lay.first_free = 16'($urandom_range(0, 72));
            end
            drain_results();
            write_reg(CFG_TOTAL_PAGES, lay.total);
            write_reg(CFG_BASE_PAGES, 16'(lay.base));
            write_reg(CFG_HOLE_FIRST_PAGE, lay.hole_first);
            write_reg(CFG_HOLE_END_PAGE, lay.hole_end);
            write_reg(CFG_FREE_START_PAGE, lay.first_free);
            quiet = ($urandom_range(0, 3) == 0);
            held_frames.delete();
            if (p < NUM_FIXED || $urandom_range(0, 2) != 0) begin
                send_word(MODE_INIT, pick_frame(), PREDICT, UNTYPED, res);
            end
            phase_goal = words_sent + PHASE_WORDS;
            while (words_sent < phase_goal) begin
                if ($urandom_range(0, 79) == 0) drain_results();
                roll = $urandom_range(0, 999);
                if (roll < 350) begin
                    // allocate a frame, maybe share it, then keep it or release it one way or another
                    send_word(MODE_ALLOC, pick_frame(), PREDICT, UNTYPED, res);
                    if (res.status == STAT_OK) begin
                        f = res.frame;
                        k = $urandom_range(0, 3);
                        repeat (k) send_word(MODE_INC, f, PREDICT, UNTYPED, res);
                        if ($urandom_range(0, 3) == 0) begin
                            held_frames.push_back(f);
                            if (held_frames.size() > 16) void'(held_frames.pop_front());
                        end else if ($urandom_range(0, 1) == 0) begin
                            repeat (k + 1) send_word(MODE_DEC, f, PREDICT, UNTYPED, res);
                        end else begin
                            repeat (k) send_word(MODE_DEC, f, PREDICT, UNTYPED, res);
                            send_word(MODE_FREE, f, PREDICT, UNTYPED, res);
                        end
                    end
                end else begin
                    if (roll < 353) begin
                        m = MODE_INIT;
                    end else if (roll < 560) begin
                        m = MODE_ALLOC;
                    end else if (roll < 700) begin
                        m = MODE_FREE;
                    end else if (roll < 820) begin
                        m = MODE_DEC;
                    end else if (roll < 960) begin
                        m = MODE_INC;
                    end else begin
                        m = 3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
                    end
                    send_word(m, pick_frame(), PREDICT, UNTYPED, res);
                end
            end
        end

        quiet = 1'b0;
        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d words, %0d of them init sweeps, across %0d frame layouts",
                 words_sent, inits_sent, NUM_PHASES + 2);
        $display("Checked %0d results: ok %0d, empty %0d, refused %0d, range %0d, limit %0d",
                 results_seen, status_seen[STAT_OK], status_seen[STAT_EMPTY],
                 status_seen[STAT_REFUSED], status_seen[STAT_RANGE], status_seen[STAT_LIMIT]);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #48_000_000;
        $display("Timeout with %0d results still due", results_due.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pfa_pkg.sv
rtl/pfa_ram.sv
rtl/pfa_cfg.sv
rtl/page_frame_allocator.sv
bench/tb.sv
